// ===== hw/rtl/swa_pkg.sv =====
// Shared constants and types for the sliding window average core.
package swa_pkg;

  localparam int CFG_W = 7;
  localparam int OUT_W = 24;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd5;

  typedef struct packed {
    logic idle;
    logic done;
  } swa_div_status_t;

endpackage

// ===== hw/rtl/swa_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module swa_div
  import swa_pkg::*;
#(
  parameter int DIV_W = 30,
  parameter int K_W   = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [K_W-1:0]   divisor,
  input  logic             neg_in,
  input  logic             ack,
  output swa_div_status_t  status,
  output logic [DIV_W-1:0] quotient,
  output logic             neg_out
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t           state;
  logic [K_W-1:0]   rem;
  logic [K_W-1:0]   dvs;
  logic [DIV_W-1:0] shreg;
  logic [CNT_W-1:0] cnt;

  logic [K_W:0]     trial;
  logic             fits;
  logic [K_W:0]     diff;

  // The dividend shifts out of the top of shreg while quotient bits shift in below.
  always_comb begin
    trial = {rem, shreg[DIV_W-1]};
    fits  = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state   <= ST_RUN;
            rem     <= '0;
            dvs     <= divisor;
            shreg   <= dividend;
            neg_out <= neg_in;
            cnt     <= CNT_W'(DIV_W);
          end
        end
        ST_RUN: begin
          rem   <= fits ? diff[K_W-1:0] : trial[K_W-1:0];
          shreg <= {shreg[DIV_W-2:0], fits};
          cnt   <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (ack) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign status.idle = (state == ST_IDLE);
  assign status.done = (state == ST_DONE);
  assign quotient    = shreg;

endmodule

// ===== hw/rtl/sliding_window_average_core.sv =====
// Boxcar moving average over the last K samples with a serial divider by K.
// A sample that completes a window gives its average after the window update, one divider step
//   per quotient bit and the output load.
// A new sample waits until the window update is done and the divider is idle; a stalled
//   output beat holds the divider and so the input too.
// Reset clears the window, empties the output register and loads window_len with 5.
module sliding_window_average_core
  import swa_pkg::*;
#(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [CFG_W-1:0]                    cfg_wr_data,  // window_len
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,      // sample
  input  logic [0:0]                          s_tuser,      // restart
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [OUT_W-1:0]                    m_tdata       // average
);

  localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int K_W   = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W = K_W + 1;
  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX);
  localparam int DIV_W = SUM_W + FRAC_BITS;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  state_t                   state;
  logic [CFG_W-1:0]         window_len;
  logic signed [SUM_W-1:0]  running_sum;
  logic [K_W-1:0]           fill_count;
  logic [PTR_W-1:0]         write_pointer;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                     sub_q;

  logic signed [SAMPLE_BITS-1:0] sample_line [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic [PTR_W-1:0]         rd_addr;
  logic                     wr_en;

  logic [K_W-1:0]           k;
  logic                     accept;
  logic                     restart;
  logic signed [SUM_W-1:0]  sum_eff;
  logic [K_W-1:0]           fill_eff;
  logic [PTR_W-1:0]         wp_eff;
  logic [IDX_W-1:0]         wp_ext;
  logic [IDX_W-1:0]         k_ext;
  logic [IDX_W-1:0]         oldest;

  logic signed [SUM_W-1:0]  running_sum_next;
  logic [K_W-1:0]           fill_count_next;
  logic [PTR_W-1:0]         write_pointer_next;
  logic [SUM_W-1:0]         sum_mag;

  logic                     div_start;
  logic [DIV_W-1:0]         div_dividend;
  logic                     div_ack;
  swa_div_status_t          div_status;
  logic [DIV_W-1:0]         div_quotient;
  logic                     div_neg;
  logic signed [DIV_W:0]    quot_signed;

  // A zero length acts as one, and lengths past the delay line are clamped to it.
  always_comb begin
    if (window_len == '0) begin
      k = K_W'(1);
    end else if (32'(window_len) > WINDOW_MAX) begin
      k = K_W'(WINDOW_MAX);
    end else begin
      k = K_W'(window_len);
    end
  end

  assign s_tready = (state == ST_IDLE) && div_status.idle;
  assign accept   = s_tvalid && s_tready;
  assign restart  = s_tuser[0];

  // A restart clears the window before its own sample is taken.
  always_comb begin
    sum_eff  = restart ? '0 : running_sum;
    fill_eff = restart ? '0 : fill_count;
    wp_eff   = restart ? '0 : write_pointer;
    wp_ext   = IDX_W'(wp_eff);
    k_ext    = IDX_W'(k);
    if (wp_ext >= k_ext) begin
      oldest = wp_ext - k_ext;
    end else begin
      oldest = wp_ext + IDX_W'(WINDOW_MAX) - k_ext;
    end
    rd_addr = oldest[PTR_W-1:0];
  end

  always_comb begin
    running_sum_next = running_sum - (sub_q ? SUM_W'(rd_data) : '0) + SUM_W'(sample_q);
    fill_count_next  = (fill_count < k) ? fill_count + 1'b1 : fill_count;
    if (write_pointer == PTR_W'(WINDOW_MAX - 1)) begin
      write_pointer_next = '0;
    end else begin
      write_pointer_next = write_pointer + 1'b1;
    end
    sum_mag      = running_sum_next[SUM_W-1] ? -running_sum_next : running_sum_next;
    div_dividend = DIV_W'(sum_mag) << FRAC_BITS;
    wr_en        = (state == ST_UPDATE);
    div_start    = (state == ST_UPDATE) && (fill_count_next >= k);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= sample_line[rd_addr];
    end
    if (wr_en) begin
      sample_line[write_pointer] <= sample_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      window_len    <= CFG_RESET;
      running_sum   <= '0;
      fill_count    <= '0;
      write_pointer <= '0;
      sub_q         <= 1'b0;
    end else if (cfg_wr_en) begin
      window_len    <= cfg_wr_data;
      running_sum   <= '0;
      fill_count    <= '0;
      write_pointer <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state         <= ST_UPDATE;
            sample_q      <= s_tdata[SAMPLE_BITS-1:0];
            running_sum   <= sum_eff;
            fill_count    <= fill_eff;
            write_pointer <= wp_eff;
            sub_q         <= (fill_eff >= k);
          end
        end
        ST_UPDATE: begin
          state         <= ST_IDLE;
          running_sum   <= running_sum_next;
          fill_count    <= fill_count_next;
          write_pointer <= write_pointer_next;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  swa_div #(
    .DIV_W (DIV_W),
    .K_W   (K_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (k),
    .neg_in   (running_sum_next[SUM_W-1]),
    .ack      (div_ack),
    .status   (div_status),
    .quotient (div_quotient),
    .neg_out  (div_neg)
  );

  assign div_ack     = div_status.done && (!m_tvalid || m_tready);
  assign quot_signed = div_neg ? -{1'b0, div_quotient} : {1'b0, div_quotient};

  // The output register frees the divider while a finished beat waits downstream.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (div_ack) begin
      m_tvalid <= 1'b1;
      m_tdata  <= OUT_W'(quot_signed);
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/swa_checker.sv =====
// Port-level checks for the sliding window average core, bound to the top level.
module swa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // The output register comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat valid right after reset");

  // One sample is in work at a time, so the input closes after each beat.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready in the cycle after an accepted beat");

  // No average can appear before the window update and division have begun.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !$rose(m_tvalid) ##1 !$rose(m_tvalid))
    else $error("output beat appeared too soon after an input beat");

  // A stalled output beat holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled output beat changed or dropped");

endmodule

bind sliding_window_average_core swa_checker u_swa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
